// ----- sv/textured_wall_column_top_assert.svh -----
// ----------------------------------------------------------------------------
// Textured wall column - assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_WALL_COLUMN_TOP_ASSERT_SVH
`define TEXTURED_WALL_COLUMN_TOP_ASSERT_SVH

// same-cycle implication
`define TWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/twc_pkg.sv -----
// ----------------------------------------------------------------------------
// Textured wall column - package
// Widths, codes, item types and the shading function.
// ----------------------------------------------------------------------------
`default_nettype none

package twc_pkg;

    localparam int unsigned TEX_SIZE_DEF    = 64;
    localparam int unsigned SCREEN_ROWS_DEF = 480;
    localparam int unsigned STORE_DEPTH     = 16384;
    localparam int unsigned ADDR_W          = 14;
    localparam int unsigned COLOR_W         = 24;
    localparam int unsigned COORD_W         = 12;
    localparam int unsigned FIX_W           = 16;
    localparam int unsigned HALF_W          = 15;
    localparam int unsigned STEP_W          = 32;
    localparam int unsigned DIFF_W          = 18;
    localparam int unsigned MUL_A_W         = 18;
    localparam int unsigned MUL_B_W         = 33;
    localparam int unsigned PROD_W          = 33;
    localparam int unsigned FRAC_W          = 22;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 16;

    localparam logic [COLOR_W-1:0] SHADE_MASK = 24'h7F7F7F;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_EMIT  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X  = 2'd0,
        CFG_POS_Y  = 2'd1,
        CFG_DARKEN = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALL,
        ST_DIV,
        ST_MUL,
        ST_POS
    } state_t;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [ADDR_W-1:0]       texel_addr;
        logic [COLOR_W-1:0]      texel_color;
        logic [COORD_W-1:0]      slice_x;
        logic                    side;
        logic signed [FIX_W-1:0] dir_x;
        logic signed [FIX_W-1:0] dir_y;
        logic [FIX_W-1:0]        wall_depth;
        logic [COORD_W-1:0]      line_start;
        logic [COORD_W-1:0]      line_end;
        logic [FIX_W-1:0]        line_height;
        logic [HALF_W-1:0]       half_height;
    } cmd_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pix_item_t;

    function automatic logic [COLOR_W-1:0] shade_half(input logic [COLOR_W-1:0] c,
                                                      input logic en);
        return en ? ((c >> 1) & SHADE_MASK) : c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/twc_if.sv -----
// ----------------------------------------------------------------------------
// Textured wall column - channel interfaces
// Valid/ready channels for command items and pixel items.
// ----------------------------------------------------------------------------
`default_nettype none

interface twc_cmd_if import twc_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface twc_pix_if import twc_pkg::*; ();
    logic      valid;
    logic      ready;
    pix_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ----- sv/twc_ram.sv -----
// ----------------------------------------------------------------------------
// Textured wall column - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/textured_wall_column_top.sv -----
// ----------------------------------------------------------------------------
// Textured wall column - top level
// Load texel: written into the texture RAM as the item is taken. Start column:
// busy through multiply, the bit-serial step divider, multiply and store.
// Emit: the texture RAM read register and the output register lie between
// item and pixel; one pixel per cycle while the pixel receiver is ready.
// Reset clears control, config and column state; data registers and RAM hold none.
// ----------------------------------------------------------------------------
`default_nettype none

module textured_wall_column_top import twc_pkg::*; #(
    parameter int unsigned TEX_SIZE    = TEX_SIZE_DEF,
    parameter int unsigned SCREEN_ROWS = SCREEN_ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    twc_cmd_if.sink               cmd_ch,
    twc_pix_if.source             pix_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned TEX_BITS = $clog2(TEX_SIZE);
    localparam int unsigned NUM_W    = TEX_BITS + 17;
    localparam int unsigned CNT_W    = $clog2(NUM_W + 1);
    localparam int unsigned TADDR_W  = 2 + 2 * TEX_BITS;
    localparam logic [NUM_W-1:0]  DIV_NUM = NUM_W'(TEX_SIZE) << 16;
    localparam logic [DIFF_W-1:0] ROWS_K  = DIFF_W'(SCREEN_ROWS);

    localparam logic [1:0] FACE_Y_POS = 2'd0;
    localparam logic [1:0] FACE_X_NEG = 2'd1;
    localparam logic [1:0] FACE_Y_NEG = 2'd2;
    localparam logic [1:0] FACE_X_POS = 2'd3;

    // configuration
    logic [FIX_W-1:0] pos_x_reg, pos_y_reg;
    logic             darken_reg;

    // column state
    logic [1:0]          face_reg;
    logic [TEX_BITS-1:0] tex_col_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   rowpos_reg;
    logic [COORD_W-1:0]  cur_row_reg, end_row_reg, col_x_reg;
    logic                side_reg;

    // start sequencer
    state_t                   state_reg, state_next;
    logic signed [FIX_W-1:0]  dir_reg;
    logic [FIX_W-1:0]         dist_reg, height_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [FIX_W-1:0]         rem_reg, rem_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg;

    // emit pipeline
    logic               a_valid_reg, a_valid_next;
    logic [COORD_W-1:0] a_x_reg, a_y_reg;
    logic               a_last_reg, a_dark_reg, a_side_reg;
    logic               out_valid_reg, out_valid_next;
    pix_item_t          out_item_reg;

    logic                             advance, accept;
    logic                             load_fire, start_fire, emit_fire;
    logic signed [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
    logic [FIX_W:0]                   trial, trial_sub;
    logic                             trial_ge, div_last;
    logic [7:0]                       pos_lo;
    logic [FRAC_W-1:0]                wall_frac;
    logic [TEX_BITS-1:0]              tcol_raw;
    logic [TADDR_W-1:0]               taddr_full;
    logic [ADDR_W-1:0]                rd_addr;
    logic [COLOR_W-1:0]               rd_data;
    logic [1:0]                       face_start;
    logic [DIFF_W-1:0]                diff_start;

    // handshake
    assign advance      = a_valid_reg && (!out_valid_reg || pix_ch.ready);
    assign cmd_ch.ready = (state_reg == ST_IDLE) && (!a_valid_reg || advance);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign load_fire    = accept && (cmd_ch.item.cmd == CMD_LOAD);
    assign start_fire   = accept && (cmd_ch.item.cmd == CMD_START);
    assign emit_fire    = accept && (cmd_ch.item.cmd == CMD_EMIT)
                          && (cur_row_reg < end_row_reg);

    assign a_valid_next   = emit_fire || (a_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !pix_ch.ready);

    assign pix_ch.valid = out_valid_reg;
    assign pix_ch.item  = out_item_reg;

    // texture store
    assign taddr_full = {face_reg, rowpos_reg[16 +: TEX_BITS], tex_col_reg};
    assign rd_addr    = ADDR_W'(taddr_full);

    twc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_fire),
        .waddr (cmd_ch.item.texel_addr),
        .wdata (cmd_ch.item.texel_color),
        .re    (emit_fire),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // start decode
    always_comb
    begin
        if (cmd_ch.item.side)
        begin
            face_start = (!cmd_ch.item.dir_y[FIX_W-1] && (|cmd_ch.item.dir_y))
                         ? FACE_Y_POS : FACE_Y_NEG;
        end
        else
        begin
            face_start = cmd_ch.item.dir_x[FIX_W-1] ? FACE_X_NEG : FACE_X_POS;
        end
    end

    assign diff_start = DIFF_W'({cmd_ch.item.line_start, 1'b0})
                        + DIFF_W'({cmd_ch.item.half_height, 1'b0}) - ROWS_K;

    // shared multiplier
    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            mul_a = diff_reg;
            mul_b = $signed({1'b0, step_reg});
        end
        else
        begin
            mul_a = $signed({2'b00, dist_reg});
            mul_b = MUL_B_W'(dir_reg);
        end
    end

    assign mul_full = mul_a * mul_b;

    // texture column from the hit fraction
    assign pos_lo    = side_reg ? pos_x_reg[7:0] : pos_y_reg[7:0];
    assign wall_frac = {pos_lo, 14'b0} + prod_reg[FRAC_W-1:0];
    assign tcol_raw  = wall_frac[FRAC_W-1 -: TEX_BITS];

    // one restoring divide step
    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, height_reg};
    assign trial_sub = trial - {1'b0, height_reg};
    assign rem_next  = trial_ge ? trial_sub[FIX_W-1:0] : trial[FIX_W-1:0];
    assign quo_next  = {quo_reg[NUM_W-2:0], trial_ge};
    assign div_last  = cnt_reg == CNT_W'(NUM_W - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start_fire) state_next = ST_WALL;
            ST_WALL: state_next = ST_DIV;
            ST_DIV:  if (div_last) state_next = ST_MUL;
            ST_MUL:  state_next = ST_POS;
            ST_POS:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            darken_reg    <= 1'b0;
            face_reg      <= '0;
            tex_col_reg   <= '0;
            step_reg      <= '0;
            rowpos_reg    <= '0;
            cur_row_reg   <= '0;
            end_row_reg   <= '0;
            side_reg      <= 1'b0;
            col_x_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POS_X:  pos_x_reg  <= cfg_data;
                    CFG_POS_Y:  pos_y_reg  <= cfg_data;
                    CFG_DARKEN: darken_reg <= cfg_data[0];
                    default:    ;
                endcase
            end

            if (start_fire)
            begin
                face_reg    <= face_start;
                cur_row_reg <= cmd_ch.item.line_start;
                end_row_reg <= cmd_ch.item.line_end;
                side_reg    <= cmd_ch.item.side;
                col_x_reg   <= cmd_ch.item.slice_x;
                cnt_reg     <= '0;
            end

            if (state_reg == ST_DIV)
            begin
                cnt_reg     <= cnt_reg + 1'b1;
                tex_col_reg <= face_reg[1] ? tcol_raw : ~tcol_raw;
                if (div_last)
                begin
                    step_reg <= (height_reg == '0) ? '1 : STEP_W'(quo_next);
                end
            end

            if (state_reg == ST_POS)
            begin
                rowpos_reg <= prod_reg[STEP_W:1];
            end

            if (emit_fire)
            begin
                rowpos_reg  <= rowpos_reg + step_reg;
                cur_row_reg <= cur_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_fire)
        begin
            dir_reg    <= cmd_ch.item.side ? cmd_ch.item.dir_x : cmd_ch.item.dir_y;
            dist_reg   <= cmd_ch.item.wall_depth;
            height_reg <= cmd_ch.item.line_height;
            diff_reg   <= diff_start;
            rem_reg    <= '0;
            quo_reg    <= DIV_NUM;
        end
        if (state_reg == ST_WALL || state_reg == ST_MUL)
        begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (emit_fire)
        begin
            a_x_reg    <= col_x_reg;
            a_y_reg    <= cur_row_reg;
            a_last_reg <= (cur_row_reg + 1'b1) == end_row_reg;
            a_dark_reg <= darken_reg;
            a_side_reg <= side_reg;
        end
        if (advance)
        begin
            out_item_reg.pixel_x <= a_x_reg;
            out_item_reg.pixel_y <= a_y_reg;
            out_item_reg.color   <= shade_half(shade_half(rd_data, a_dark_reg), a_side_reg);
            out_item_reg.last    <= a_last_reg;
        end
    end

`include "textured_wall_column_top_assert.svh"

    `TWC_ASSERT_NOW(a_busy_not_ready, state_reg != ST_IDLE, !cmd_ch.ready, "ready while busy")
    `TWC_ASSERT_NEXT(a_emit_queued, emit_fire, a_valid_reg, "emit item lost")
    `TWC_ASSERT_NEXT(a_stage_held, a_valid_reg && !advance, a_valid_reg && $stable(a_y_reg), "stage dropped")
    `TWC_ASSERT_NOW(a_div_count, state_reg == ST_DIV, cnt_reg < CNT_W'(NUM_W), "divider overrun")

endmodule

`default_nettype wire

// ----- tb/tb_textured_wall_column_top.sv -----
// ----------------------------------------------------------------------------
// Textured wall column - testbench
// Drives load, start and emit items through the command channel, predicts
// every pixel from a local model of the texture store and column state, and
// checks each pixel item in order. Runs a short directed part and then
// random columns under steady, gappy, stalling and long-hold traffic, with
// the view registers rewritten between phases.
// ----------------------------------------------------------------------------
module tb_textured_wall_column_top import twc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEX      = TEX_SIZE_DEF;
    localparam int ROWS     = SCREEN_ROWS_DEF;
    localparam int TEX_BITS = $clog2(TEX);
    localparam int SETTLE   = 40;
    localparam int HOLD_LEN = 300;
    localparam int LIMIT    = 4000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] FACE_Y_POS = 2'd0;
    localparam logic [1:0] FACE_X_NEG = 2'd1;
    localparam logic [1:0] FACE_Y_NEG = 2'd2;
    localparam logic [1:0] FACE_X_POS = 2'd3;

    typedef enum int {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH,
        PH_HOLD
    } pace_t;

    typedef struct packed {
        logic [1:0]          face;
        logic [TEX_BITS-1:0] tcol;
        logic [31:0]         step;
        logic [31:0]         pos;
        logic [11:0]         cur_row;
        logic [11:0]         end_row;
        logic                side_hit;
        logic [11:0]         col_x;
    } col_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    twc_cmd_if cmd_if ();
    twc_pix_if pix_if ();

    textured_wall_column_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_if),
        .pix_ch    (pix_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // command items waiting to be driven, pixels waiting to come out
    cmd_item_t   cmd_backlog [$];
    pix_item_t   pixels_due [$];

    // texture contents as seen by the checker, and texels written as planned
    logic [COLOR_W-1:0] tex_mem [STORE_DEPTH];
    bit                 tex_known [STORE_DEPTH];

    logic [15:0] view_x  = '0;
    logic [15:0] view_y  = '0;
    logic        dim_all = 1'b0;
    col_t        column  = '0;
    col_t        plan    = '0;

    pace_t     pace = PH_STEADY;
    int        hold_count = 0;
    int        cmds_queued = 0;
    int        cmds_taken = 0;
    int        loads_seen = 0;
    int        starts_seen = 0;
    int        pixels_checked = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    bit        cmd_fire = 1'b0;
    bit        sender_rest;
    cmd_item_t got;
    pix_item_t want;
    pix_item_t seen;
    pix_item_t px;
    logic [ADDR_W-1:0] idx;

    function automatic col_t column_setup(cmd_item_t it, logic [15:0] px_pos,
                                          logic [15:0] py_pos);
        col_t   c;
        longint hit;
        longint rows2;
        longint prod;
        int     tc;
        c = '0;
        if (it.side)
        begin
            c.face = ($signed(it.dir_y) > 0) ? FACE_Y_POS : FACE_Y_NEG;
            hit = longint'(px_pos) * 16384
                + longint'(it.wall_depth) * longint'($signed(it.dir_x));
        end
        else
        begin
            c.face = ($signed(it.dir_x) < 0) ? FACE_X_NEG : FACE_X_POS;
            hit = longint'(py_pos) * 16384
                + longint'(it.wall_depth) * longint'($signed(it.dir_y));
        end
        tc = int'((longint'(hit[FRAC_W-1:0]) * TEX) >> FRAC_W);
        if (c.face == FACE_Y_POS || c.face == FACE_X_NEG)
        begin
            tc = TEX - 1 - tc;
        end
        c.tcol = TEX_BITS'(tc);
        if (it.line_height == '0)
        begin
            c.step = 32'hFFFF_FFFF;
        end
        else
        begin
            c.step = 32'((longint'(TEX) << 16) / longint'(it.line_height));
        end
        rows2 = 2 * longint'(it.line_start) - ROWS + 2 * longint'(it.half_height);
        prod = rows2 * longint'(c.step);
        c.pos = prod[32:1];
        c.cur_row = it.line_start;
        c.end_row = it.line_end;
        c.side_hit = it.side;
        c.col_x = it.slice_x;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] texel_index(col_t c);
        int row;
        row = int'(c.pos >> 16) & (TEX - 1);
        return ADDR_W'(int'(c.face) * TEX * TEX + row * TEX + int'(c.tcol));
    endfunction

    function automatic col_t column_advance(col_t c);
        c.pos = c.pos + c.step;
        c.cur_row = c.cur_row + 12'd1;
        return c;
    endfunction

    function automatic logic [COLOR_W-1:0] halve_rgb(logic [COLOR_W-1:0] c);
        return {1'b0, c[23:17], 1'b0, c[15:9], 1'b0, c[7:1]};
    endfunction

    function automatic cmd_item_t random_cmd(logic [1:0] op);
        cmd_item_t it;
        it.cmd         = op;
        it.texel_addr  = ADDR_W'($urandom);
        it.texel_color = COLOR_W'($urandom);
        it.slice_x     = COORD_W'($urandom);
        it.side        = 1'($urandom);
        it.dir_x       = FIX_W'($urandom);
        it.dir_y       = FIX_W'($urandom);
        it.wall_depth  = FIX_W'($urandom);
        it.line_start  = COORD_W'($urandom);
        it.line_end    = COORD_W'($urandom);
        it.line_height = FIX_W'($urandom);
        it.half_height = HALF_W'($urandom);
        return it;
    endfunction

    task automatic report_error(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Queue one item; an emit that would read a texel not yet written gets a
    // load of that texel ahead of it.
    task automatic queue_cmd(cmd_item_t it);
        cmd_item_t fill;
        logic [ADDR_W-1:0] a;
        case (it.cmd)
            CMD_LOAD:
            begin
                tex_known[it.texel_addr] = 1'b1;
            end
            CMD_START:
            begin
                plan = column_setup(it, view_x, view_y);
            end
            CMD_EMIT:
            begin
                if (plan.cur_row < plan.end_row)
                begin
                    a = texel_index(plan);
                    if (!tex_known[a])
                    begin
                        fill = random_cmd(CMD_LOAD);
                        fill.texel_addr = a;
                        cmd_backlog.push_back(fill);
                        cmds_queued++;
                        tex_known[a] = 1'b1;
                    end
                    plan = column_advance(plan);
                end
            end
            default:
            begin
            end
        endcase
        cmd_backlog.push_back(it);
        cmds_queued++;
    endtask

    task automatic queue_start(logic sd, logic [15:0] dx, logic [15:0] dy,
                               logic [15:0] hit_len, logic [11:0] ls, logic [11:0] le,
                               logic [15:0] h, logic [14:0] half, logic [11:0] sx);
        cmd_item_t it;
        it = random_cmd(CMD_START);
        it.side = sd;
        it.dir_x = dx;
        it.dir_y = dy;
        it.wall_depth = hit_len;
        it.line_start = ls;
        it.line_end = le;
        it.line_height = h;
        it.half_height = half;
        it.slice_x = sx;
        queue_cmd(it);
    endtask

    task automatic queue_emits(int n);
        repeat (n)
        begin
            queue_cmd(random_cmd(CMD_EMIT));
        end
    endtask

    task automatic queue_random(int n);
        int goal;
        int pick;
        int len;
        logic [11:0] ls;
        logic [11:0] le;
        logic [15:0] h;
        logic [15:0] dx;
        logic [15:0] dy;
        goal = cmds_queued + n;
        while (cmds_queued < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                queue_cmd(random_cmd(CMD_LOAD));
            end
            else if (pick < 11)
            begin
                queue_cmd(random_cmd(CMD_UNUSED));
            end
            else
            begin
                ls = 12'($urandom);
                if (pick < 20)
                begin
                    len = $urandom_range(2);
                    le = 12'($urandom_range(int'(ls)));
                end
                else
                begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(48, 13)
                                                   : $urandom_range(12, 1);
                    le = (int'(ls) + len > 4095) ? 12'hFFF : 12'(int'(ls) + len);
                end
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    h = 16'd0;
                end
                else if (pick < 35)
                begin
                    h = 16'($urandom_range(200, 1));
                end
                else
                begin
                    h = 16'($urandom);
                end
                dx = 16'($urandom);
                dy = 16'($urandom);
                case ($urandom_range(7))
                    0: dx = 16'h0000;
                    1: dy = 16'h0000;
                    2: dx = 16'h8000;
                    3: dy = 16'h7FFF;
                    default:
                    begin
                    end
                endcase
                queue_start(1'($urandom), dx, dy, 16'($urandom), ls, le, h,
                            15'($urandom), 12'($urandom));
                queue_emits(len + (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0));
            end
        end
    endtask

    task automatic set_view(logic [15:0] x_pos, logic [15:0] y_pos, logic dim);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_POS_X;
        cfg_data <= x_pos;
        @(negedge clk);
        cfg_index <= CFG_POS_Y;
        cfg_data <= y_pos;
        @(negedge clk);
        cfg_index <= CFG_DARKEN;
        cfg_data <= {{(CFG_DATA_W-1){1'b0}}, dim};
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (cmds_taken != cmds_queued || pixels_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // command side: register writes and the checker's copy of the block
    always @(posedge clk)
    begin
        cmd_fire = rst_n && cmd_if.valid && cmd_if.ready;
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                CFG_POS_X:  view_x = cfg_data;
                CFG_POS_Y:  view_y = cfg_data;
                CFG_DARKEN: dim_all = cfg_data[0];
                default:
                begin
                end
            endcase
        end
        if (cmd_fire)
        begin
            got = cmd_if.item;
            cmds_taken++;
            case (got.cmd)
                CMD_LOAD:
                begin
                    tex_mem[got.texel_addr] = got.texel_color;
                    loads_seen++;
                end
                CMD_START:
                begin
                    column = column_setup(got, view_x, view_y);
                    starts_seen++;
                end
                CMD_EMIT:
                begin
                    if (column.cur_row < column.end_row)
                    begin
                        idx = texel_index(column);
                        px.pixel_x = column.col_x;
                        px.pixel_y = column.cur_row;
                        px.color = tex_mem[idx];
                        if (dim_all)
                        begin
                            px.color = halve_rgb(px.color);
                        end
                        if (column.side_hit)
                        begin
                            px.color = halve_rgb(px.color);
                        end
                        px.last = (int'(column.cur_row) + 1 == int'(column.end_row));
                        pixels_due.push_back(px);
                        column = column_advance(column);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            seen = pix_if.item;
            if (pixels_due.size() == 0)
            begin
                report_error($sformatf("pixel x=%0d y=%0d with none expected",
                                       seen.pixel_x, seen.pixel_y));
            end
            else
            begin
                want = pixels_due.pop_front();
                pixels_checked++;
                if (seen.pixel_x !== want.pixel_x)
                begin
                    report_error($sformatf("pixel_x %0d, want %0d",
                                           seen.pixel_x, want.pixel_x));
                end
                if (seen.pixel_y !== want.pixel_y)
                begin
                    report_error($sformatf("pixel_y %0d, want %0d",
                                           seen.pixel_y, want.pixel_y));
                end
                if (seen.color !== want.color)
                begin
                    report_error($sformatf("color %06h, want %06h at row %0d",
                                           seen.color, want.color, want.pixel_y));
                end
                if (seen.last !== want.last)
                begin
                    report_error($sformatf("last %0b, want %0b at row %0d",
                                           seen.last, want.last, want.pixel_y));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cmd_if.item <= '0;
        end
        else if (!cmd_if.valid || cmd_fire)
        begin
            sender_rest = (pace == PH_SRC_GAPS && $urandom_range(99) < 81)
                       || (pace == PH_BOTH && $urandom_range(99) < 35);
            if (cmd_backlog.size() != 0 && !sender_rest)
            begin
                cmd_if.item <= cmd_backlog.pop_front();
                cmd_if.valid <= 1'b1;
            end
            else
            begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold during the pressure phase
    always @(negedge clk)
    begin
        if (pace == PH_HOLD && hold_count < HOLD_LEN)
        begin
            hold_count <= hold_count + 1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pix_if.ready <= 1'b0;
        end
        else
        begin
            case (pace)
                PH_SINK_STALLS: pix_if.ready <= ($urandom_range(99) >= 81);
                PH_BOTH:        pix_if.ready <= ($urandom_range(99) >= 35);
                PH_HOLD:        pix_if.ready <= (hold_count >= HOLD_LEN);
                default:        pix_if.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", LIMIT);
            $display("[textured_wall_column_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_POS_X;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_view(16'h0180, 16'h0A40, 1'b0);

        // directed: emit before any start, unknown command, extreme loads
        queue_emits(1);
        queue_cmd(random_cmd(CMD_UNUSED));
        begin
            cmd_item_t it;
            it = random_cmd(CMD_LOAD);
            it.texel_addr = '0;
            it.texel_color = '0;
            queue_cmd(it);
            it.texel_addr = '1;
            it.texel_color = '1;
            queue_cmd(it);
        end
        // zero line height, extreme direction and distance, emit past the end
        queue_start(1'b1, 16'h8000, 16'h4000, 16'hFFFF, 12'd0, 12'd2,
                    16'd0, 15'd0, 12'd0);
        queue_emits(3);
        queue_start(1'b0, 16'h8000, 16'h7FFF, 16'h0000, 12'd4094, 12'd4095,
                    16'hFFFF, 15'h7FFF, 12'hFFF);
        queue_emits(2);
        // empty column
        queue_start(1'b0, 16'h0000, 16'h8000, 16'h0100, 12'd10, 12'd10,
                    16'd64, 15'd0, 12'd7);
        queue_emits(1);
        queue_start(1'b1, 16'h7FFF, 16'h0000, 16'h0280, 12'd239, 12'd242,
                    16'd1, 15'd0, 12'd320);
        queue_emits(3);
        wait_drained();

        set_view(16'hFFFF, 16'h0000, 1'b1);
        pace = PH_SRC_GAPS;
        queue_random(90);
        wait_drained();

        set_view(16'($urandom), 16'($urandom), 1'b0);
        pace = PH_SINK_STALLS;
        queue_random(90);
        wait_drained();

        set_view(16'h0000, 16'hFFFF, 1'b1);
        pace = PH_BOTH;
        queue_random(90);
        wait_drained();

        set_view(16'($urandom), 16'($urandom), 1'($urandom));
        pace = PH_HOLD;
        queue_random(90);
        wait_drained();

        set_view(16'($urandom), 16'($urandom), 1'b0);
        pace = PH_STEADY;
        queue_random(90);
        wait_drained();

        if (pixels_due.size() != 0)
        begin
            report_error($sformatf("%0d pixels never came out", pixels_due.size()));
        end
        $display("run: %0d command items (%0d texel loads, %0d column starts), %0d pixels checked",
                 cmds_taken, loads_seen, starts_seen, pixels_checked);
        $display("traffic: steady, sender gaps, receiver stalls, both, one long receiver hold");
        if (error_count == 0)
        begin
            $display("[textured_wall_column_top] OK");
        end
        else
        begin
            $display("[textured_wall_column_top] ERROR");
        end
        $finish;
    end

endmodule
